@@ design/kway_run_merger_macros.svh @@
// Assertion macros for the merger's top-level RTL file.
`ifndef KWAY_RUN_MERGER_MACROS_SVH
`define KWAY_RUN_MERGER_MACROS_SVH

// The property must hold in the same cycle as the condition.
`define KWM_ASSERT_NOW(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (prop)) \
    else $error("kway_run_merger: same-cycle check failed");

// The property must hold in the cycle after the condition.
`define KWM_ASSERT_NEXT(label, cond, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) \
    else $error("kway_run_merger: next-cycle check failed");

`endif

@@ design/kwm_pkg.sv @@
// Types and constants shared by the k-way run merger modules.
package kwm_pkg;

  localparam int RUN_COUNT_W = 5;
  localparam int RUN_IDX_W   = 4;
  localparam int SEQ_W       = 32;
  localparam int POS_W       = 32;
  localparam int DATA_W      = 64;
  localparam int HEAD_W      = SEQ_W + POS_W + DATA_W;
  localparam int TDATA_W     = 136;

  localparam logic CMD_RECORD = 1'b0;
  localparam logic CMD_END    = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_DRAIN,
    S_OUT
  } st_t;

  typedef struct packed {
    logic clear;
    logic live;
    logic is_default;
  } trk_ctl_t;

endpackage

@@ design/kway_run_merger.sv @@
// Top level of the k-way run merger: control, run flags and output register.
//
//   channel  | direction | tdata fields (low bit up)            | tuser
//   s_axis   | in        | run_index, seq_id, position, payload  | command
//   m_axis   | out       | refill_run, out_seq_id, out_position, | finished
//            |           | out_payload                           |
//   cfg      | in        | run_count written when cfg_wr_en high | -
//
// An ignored request leaves the block idle; one with no result goes from check to idle.
// One that yields a record runs check, a scan of the n active runs reading one head a cycle
// from the head store's single read port, drain and output; a finished one check and output.
// Reset clears the per-run flags at once; the head store needs no clearing pass.
// Input is taken only when no request is at work; a stalled result holds the block
// in its output state until the previous result is taken.
`include "kway_run_merger_macros.svh"

module kway_run_merger import kwm_pkg::*; #(
  parameter int MAX_RUNS = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // run_index[3:0], seq_id[35:4], position[67:36], payload[131:68], zero pad
  input  logic [TDATA_W-1:0]     s_axis_tdata,
  // command[0]
  input  logic [0:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // refill_run[3:0], out_seq_id[35:4], out_position[67:36], out_payload[131:68]
  output logic [TDATA_W-1:0]     m_axis_tdata,
  // finished[0]
  output logic [0:0]             m_axis_tuser,
  input  logic                   cfg_wr_en,
  input  logic [RUN_COUNT_W-1:0] cfg_wr_data
);

  localparam int RW  = $clog2(MAX_RUNS);
  localparam int NW  = $clog2(MAX_RUNS + 1);
  localparam int CNW = (NW > RUN_COUNT_W) ? NW : RUN_COUNT_W;

  st_t st, st_next;

  logic [RUN_COUNT_W-1:0] run_count;
  logic [CNW-1:0]         n;
  logic [MAX_RUNS-1:0]    mask;
  logic [MAX_RUNS-1:0]    head_full;
  logic [MAX_RUNS-1:0]    run_ended;
  logic [RW-1:0]          default_run;

  logic                   in_cmd;
  logic [RUN_IDX_W-1:0]   in_run;
  logic [RW-1:0]          in_ridx;
  logic [SEQ_W-1:0]       in_seq;
  logic [POS_W-1:0]       in_pos;
  logic [DATA_W-1:0]      in_data;
  logic                   in_ok;
  logic                   in_accept;

  logic                   last_end;
  logic                   out_fin;
  logic                   out_load;
  logic [CNW-1:0]         cnt;
  logic                   rd_live;
  logic [RW-1:0]          rd_idx;

  logic                   hi_found;
  logic [RW-1:0]          hi_idx;
  logic [RW-1:0]          dflt_eff;
  logic                   all_ended;
  logic                   ready;
  logic                   any_full;

  logic                   ram_we;
  logic                   ram_re;
  logic [HEAD_W-1:0]      ram_rdata;
  logic                   trk_clear;
  trk_ctl_t               trk_ctl;
  logic [RW-1:0]          best_idx;
  logic [SEQ_W-1:0]       best_seq;
  logic [POS_W-1:0]       best_pos;
  logic [DATA_W-1:0]      best_data;

  logic [RUN_IDX_W-1:0]   o_refill;
  logic [SEQ_W-1:0]       o_seq;
  logic [POS_W-1:0]       o_pos;
  logic [DATA_W-1:0]      o_data;
  logic                   o_fin;

  assign in_cmd  = s_axis_tuser[0];
  assign in_run  = s_axis_tdata[3:0];
  assign in_seq  = s_axis_tdata[35:4];
  assign in_pos  = s_axis_tdata[67:36];
  assign in_data = s_axis_tdata[131:68];
  assign in_ridx = RW'(in_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_count <= RUN_COUNT_W'(1);
    end else if (cfg_wr_en) begin
      run_count <= cfg_wr_data;
    end
  end

  // A count of zero acts as one run, a count above the storage acts as all of it.
  always_comb begin
    if (run_count == '0) begin
      n = CNW'(1);
    end else if (CNW'(run_count) > CNW'(MAX_RUNS)) begin
      n = CNW'(MAX_RUNS);
    end else begin
      n = CNW'(run_count);
    end
  end

  always_comb begin
    for (int i = 0; i < MAX_RUNS; i++) begin
      mask[i] = (CNW'(i) < n);
    end
  end

  assign in_ok     = (CNW'(in_run) < n) && !head_full[in_ridx] && !run_ended[in_ridx];
  assign in_accept = s_axis_tvalid && s_axis_tready;

  // Highest active run that has not ended, for the default after an end mark.
  always_comb begin
    hi_found = 1'b0;
    hi_idx   = '0;
    for (int i = 0; i < MAX_RUNS; i++) begin
      if (mask[i] && !run_ended[i]) begin
        hi_found = 1'b1;
        hi_idx   = RW'(i);
      end
    end
  end

  assign dflt_eff  = (last_end && hi_found) ? hi_idx : default_run;
  assign all_ended = &(run_ended | ~mask);
  assign ready     = &(head_full | run_ended | ~mask);
  assign any_full  = |(head_full & mask);

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_comb begin
    st_next       = st;
    s_axis_tready = 1'b0;
    out_load      = 1'b0;
    ram_re        = 1'b0;
    trk_clear     = 1'b0;
    unique case (st)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        if (s_axis_tvalid && in_ok) begin
          st_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (all_ended) begin
          st_next = S_OUT;
        end else if (ready && any_full) begin
          st_next   = S_SCAN;
          trk_clear = 1'b1;
        end else begin
          st_next = S_IDLE;
        end
      end
      S_SCAN: begin
        ram_re = 1'b1;
        if (cnt == n - CNW'(1)) begin
          st_next = S_DRAIN;
        end
      end
      S_DRAIN: begin
        st_next = S_OUT;
      end
      S_OUT: begin
        if (!m_axis_tvalid || m_axis_tready) begin
          out_load = 1'b1;
          st_next  = S_IDLE;
        end
      end
      default: begin
        st_next = S_IDLE;
      end
    endcase
  end

  assign trk_ctl.clear      = trk_clear;
  assign trk_ctl.live       = rd_live;
  assign trk_ctl.is_default = (rd_idx == default_run);

  always_ff @(posedge clk) begin
    if (rst) begin
      head_full   <= '0;
      run_ended   <= '0;
      default_run <= '0;
      last_end    <= 1'b0;
      out_fin     <= 1'b0;
      cnt         <= '0;
      rd_live     <= 1'b0;
    end else begin
      rd_live <= (st == S_SCAN) && head_full[cnt[RW-1:0]];
      if (in_accept && in_ok) begin
        last_end <= (in_cmd == CMD_END);
        if (in_cmd == CMD_RECORD) begin
          head_full[in_ridx] <= 1'b1;
        end else begin
          run_ended[in_ridx] <= 1'b1;
        end
      end
      if (st == S_CHECK) begin
        default_run <= dflt_eff;
        out_fin     <= all_ended;
        cnt         <= '0;
      end
      if (st == S_SCAN) begin
        cnt <= cnt + CNW'(1);
      end
      if (out_load && !out_fin) begin
        head_full[best_idx] <= 1'b0;
        default_run         <= best_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    rd_idx <= cnt[RW-1:0];
  end

  assign ram_we = in_accept && in_ok && (in_cmd == CMD_RECORD);

  kwm_head_ram #(
    .DEPTH (MAX_RUNS),
    .AW    (RW)
  ) u_head_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_ridx),
    .wdata ({in_data, in_pos, in_seq}),
    .re    (ram_re),
    .raddr (cnt[RW-1:0]),
    .rdata (ram_rdata)
  );

  kwm_min_track #(
    .AW (RW)
  ) u_min_track (
    .clk       (clk),
    .rst       (rst),
    .ctl       (trk_ctl),
    .idx       (rd_idx),
    .rd_seq    (ram_rdata[SEQ_W-1:0]),
    .rd_pos    (ram_rdata[SEQ_W+POS_W-1:SEQ_W]),
    .rd_data   (ram_rdata[HEAD_W-1:SEQ_W+POS_W]),
    .best_idx  (best_idx),
    .best_seq  (best_seq),
    .best_pos  (best_pos),
    .best_data (best_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      if (out_fin) begin
        o_refill <= '0;
        o_seq    <= '0;
        o_pos    <= '0;
        o_data   <= '0;
        o_fin    <= 1'b1;
      end else begin
        o_refill <= RUN_IDX_W'(best_idx);
        o_seq    <= best_seq;
        o_pos    <= best_pos;
        o_data   <= best_data;
        o_fin    <= 1'b0;
      end
    end
  end

  assign m_axis_tdata = {4'b0000, o_data, o_pos, o_seq, o_refill};
  assign m_axis_tuser = o_fin;

  `KWM_ASSERT_NOW(a_finish_carries_no_record, m_axis_tvalid && m_axis_tuser[0], m_axis_tdata == '0)
  `KWM_ASSERT_NEXT(a_emitted_head_released, out_load && !out_fin, !head_full[$past(best_idx)])
  `KWM_ASSERT_NEXT(a_flags_hold_during_scan, st == S_SCAN, $stable(head_full))

endmodule

@@ design/kwm_head_ram.sv @@
// Head store: one entry per run, one write and one registered read port.
module kwm_head_ram import kwm_pkg::*; #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic              clk,
  input  logic              we,
  input  logic [AW-1:0]     waddr,
  input  logic [HEAD_W-1:0] wdata,
  input  logic              re,
  input  logic [AW-1:0]     raddr,
  output logic [HEAD_W-1:0] rdata
);

  logic [HEAD_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

@@ design/kwm_min_track.sv @@
// Running minimum over the heads streamed out of the head store.
module kwm_min_track import kwm_pkg::*; #(
  parameter int AW = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  trk_ctl_t          ctl,
  input  logic [AW-1:0]     idx,
  input  logic [SEQ_W-1:0]  rd_seq,
  input  logic [POS_W-1:0]  rd_pos,
  input  logic [DATA_W-1:0] rd_data,
  output logic [AW-1:0]     best_idx,
  output logic [SEQ_W-1:0]  best_seq,
  output logic [POS_W-1:0]  best_pos,
  output logic [DATA_W-1:0] best_data
);

  logic have;
  logic take;
  logic [SEQ_W+POS_W-1:0] key;
  logic [SEQ_W+POS_W-1:0] best_key;

  assign key      = {rd_seq, rd_pos};
  assign best_key = {best_seq, best_pos};

  // Heads arrive in ascending index order, so a strict compare keeps the lowest
  // index among equal keys; the default run still takes an equal key over.
  assign take = ctl.live &&
                (!have || (key < best_key) || ((key == best_key) && ctl.is_default));

  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
    end else if (ctl.clear) begin
      have <= 1'b0;
    end else if (take) begin
      have <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      best_idx  <= idx;
      best_seq  <= rd_seq;
      best_pos  <= rd_pos;
      best_data <= rd_data;
    end
  end

endmodule
